/* hdl/rcs_pkg.sv */
package rcs_pkg;

  // Largest compound packet the offsets can address
  localparam int unsigned MaxPacketBytesDefault = 65536;

  // Result queue depth; one byte can cause up to two results
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Result status codes
  localparam logic [1:0] StatusMember    = 2'd0;
  localparam logic [1:0] StatusPacketEnd = 2'd1;
  localparam logic [1:0] StatusMalformed = 2'd2;

  // RTCP header constants
  localparam logic [1:0] RtcpVersion = 2'd2;
  localparam int unsigned HeaderBytes = 8;

  // One result beat
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] member_offset;
    logic [15:0] member_length;
    logic [4:0]  format_count;
    logic [7:0]  packet_type;
    logic [31:0] header_ssrc;
    logic [15:0] body_length;
    logic        last_result;
  } result_t;

  // Results produced by one byte, handed to the queue
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_push_t;

endpackage

/* hdl/rtcp_compound_splitter_core.sv */
// RTCP compound packet splitter.
// Input channel: one packet byte per beat on data_byte_i, packet_end_i high
// on the final byte; a beat moves when in_valid_i is high and in_stall_o low.
// Output channel: one result per beat (status, member fields, last_result);
// a beat moves when out_valid_o is high and out_stall_i low.
// Each byte gives zero, one or two results: a member result when a valid
// member completes, packet end after a member closing the packet, or one
// malformed result on the first error, after which the rest of the packet
// is dropped up to its final byte.
// An accepted byte is held in the input register and parsed from there; its
// results are written into the result queue and offered from its head.
// Throughput: one byte per cycle; the four-entry result queue holds back
// input only while fewer than two entries are free, so a byte that causes
// two results costs the receiver one extra beat.
// Receiver stall: results wait in the queue, the head stays put, and once
// the queue is near full the input register holds and in_stall_o rises.
// Reset clears the packet state and empties the queue.
module rtcp_compound_splitter_core #(
  parameter int unsigned MAX_PACKET_BYTES = rcs_pkg::MaxPacketBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        packet_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] member_offset_o,
  output logic [15:0] member_length_o,
  output logic [4:0]  format_count_o,
  output logic [7:0]  packet_type_o,
  output logic [31:0] header_ssrc_o,
  output logic [15:0] body_length_o,
  output logic        last_result_o
);
  import rcs_pkg::*;

  result_push_t push;
  result_t      head;
  logic         room;

  // Byte parser with input register
  rcs_parser #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .packet_end_i(packet_end_i),
    .room_i      (room),
    .push_o      (push)
  );

  // Result queue feeding the output channel
  rcs_result_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .head_o     (head)
  );

  assign status_o        = head.status;
  assign member_offset_o = head.member_offset;
  assign member_length_o = head.member_length;
  assign format_count_o  = head.format_count;
  assign packet_type_o   = head.packet_type;
  assign header_ssrc_o   = head.header_ssrc;
  assign body_length_o   = head.body_length;
  assign last_result_o   = head.last_result;

endmodule

/* hdl/rcs_parser.sv */
module rcs_parser #(
  parameter int unsigned MAX_PACKET_BYTES = rcs_pkg::MaxPacketBytesDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  packet_end_i,
  input  logic                  room_i,
  output rcs_pkg::result_push_t push_o
);
  import rcs_pkg::*;

  localparam logic [18:0] MaxBytes = 19'(MAX_PACKET_BYTES);

  // Input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       end_q;
  logic       accept;
  logic       drain;

  // Packet state
  logic [16:0] pkt_pos_q, pkt_pos_d;
  logic [16:0] mem_pos_q, mem_pos_d;
  logic [15:0] start_q, start_d;
  logic [16:0] size_q, size_d;
  logic [7:0]  first_q, first_d;
  logic [7:0]  type_q, type_d;
  logic [31:0] ssrc_q, ssrc_d;
  logic        error_q, error_d;

  logic        bad;
  logic        emit;
  logic [18:0] size_w;
  logic [16:0] logical;
  logic [16:0] body_w;

  assign drain      = in_valid_q & room_i;
  assign in_stall_o = in_valid_q & ~room_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (drain) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
      end_q  <= packet_end_i;
    end
  end

  // Per-byte parse: header capture, length and padding checks, member, end and malformed results
  always_comb begin
    pkt_pos_d = pkt_pos_q;
    mem_pos_d = mem_pos_q;
    start_d   = start_q;
    size_d    = size_q;
    first_d   = first_q;
    type_d    = type_q;
    ssrc_d    = ssrc_q;
    error_d   = error_q;
    bad       = 1'b0;
    emit      = 1'b0;
    size_w    = 19'(({11'd0, size_q[7:0]} << 8) | {11'd0, byte_q}) + 19'd1;
    size_w    = size_w << 2;
    logical   = '0;
    body_w    = '0;
    push_o    = '0;

    if (!error_q) begin
      if ({2'b00, pkt_pos_q} >= MaxBytes) begin
        bad = 1'b1;
      end else begin
        priority if (mem_pos_q == 17'd0) begin
          first_d = byte_q;
          start_d = pkt_pos_q[15:0];
          if (byte_q[7:6] != RtcpVersion) bad = 1'b1;
        end else if (mem_pos_q == 17'd1) begin
          type_d = byte_q;
        end else if (mem_pos_q == 17'd2) begin
          size_d = {9'd0, byte_q};
        end else if (mem_pos_q == 17'd3) begin
          size_d = size_w[16:0];
          if (size_w < 19'(HeaderBytes) || size_w > (MaxBytes - {3'b000, start_q}))
            bad = 1'b1;
        end else if (mem_pos_q < 17'd8) begin
          ssrc_d = {ssrc_q[23:0], byte_q};
        end else begin
          ssrc_d = ssrc_q;
        end

        // Last byte of the member: strip padding and report
        if (!bad && mem_pos_q >= 17'd7 && mem_pos_q == size_q - 17'd1) begin
          logical = size_q;
          if (first_q[5]) begin
            if (byte_q == 8'd0 || {9'd0, byte_q} > size_q - 17'd4) begin
              bad = 1'b1;
            end else begin
              logical = size_q - {9'd0, byte_q};
              if (logical < 17'(HeaderBytes)) bad = 1'b1;
            end
          end
          if (!bad) emit = 1'b1;
        end

        if (!bad) begin
          mem_pos_d = emit ? 17'd0 : mem_pos_q + 17'd1;
          pkt_pos_d = pkt_pos_q + 17'd1;
        end
      end

      body_w = logical - 17'(HeaderBytes);

      if (bad) begin
        push_o.count              = 2'd1;
        push_o.first.status       = StatusMalformed;
        push_o.first.last_result  = 1'b1;
        error_d                   = ~end_q;
      end else if (emit) begin
        push_o.count               = end_q ? 2'd2 : 2'd1;
        push_o.first.status        = StatusMember;
        push_o.first.member_offset = start_q;
        push_o.first.member_length = logical[15:0];
        push_o.first.format_count  = first_q[4:0];
        push_o.first.packet_type   = type_q;
        push_o.first.header_ssrc   = ssrc_d;
        push_o.first.body_length   = body_w[15:0];
        push_o.first.last_result   = ~end_q;
        push_o.second.status       = StatusPacketEnd;
        push_o.second.last_result  = 1'b1;
      end else if (end_q) begin
        push_o.count              = 2'd1;
        push_o.first.status       = StatusMalformed;
        push_o.first.last_result  = 1'b1;
      end
    end

    // Final byte clears the packet state
    if (end_q) begin
      pkt_pos_d = '0;
      mem_pos_d = '0;
      start_d   = '0;
      size_d    = '0;
      first_d   = '0;
      type_d    = '0;
      ssrc_d    = '0;
      error_d   = 1'b0;
    end

    if (!drain) push_o.count = 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_pos_q <= '0;
      mem_pos_q <= '0;
      start_q   <= '0;
      size_q    <= '0;
      first_q   <= '0;
      type_q    <= '0;
      ssrc_q    <= '0;
      error_q   <= 1'b0;
    end else if (drain) begin
      pkt_pos_q <= pkt_pos_d;
      mem_pos_q <= mem_pos_d;
      start_q   <= start_d;
      size_q    <= size_d;
      first_q   <= first_d;
      type_q    <= type_d;
      ssrc_q    <= ssrc_d;
      error_q   <= error_d;
    end
  end

endmodule

/* hdl/rcs_result_queue.sv */
module rcs_result_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rcs_pkg::result_push_t push_i,
  output logic                  room_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rcs_pkg::result_t      head_o
);
  import rcs_pkg::*;

  result_t              entry_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q;
  logic [QueuePtrW-1:0] rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 pop;
  logic [QueuePtrW-1:0] wr_next;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o & ~out_stall_i;
  // Room for the two results one byte can cause
  assign room_o      = (count_q <= QueueCntW'(QueueDepth - 2));
  assign head_o      = entry_q[rd_ptr_q];
  assign wr_next     = wr_ptr_q + QueuePtrW'(1);

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) entry_q[wr_ptr_q] <= push_i.first;
    if (push_i.count == 2'd2) entry_q[wr_next]  <= push_i.second;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QueuePtrW'(push_i.count);
      if (pop) rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      count_q <= count_q + QueueCntW'(push_i.count) - QueueCntW'(pop);
    end
  end

endmodule

/* test/tb_top.sv */
module tb_top;
  import rcs_pkg::*;

  // Small offset range so that full-size packets stay short
  localparam int unsigned MaxBytes    = 256;
  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned RandomBytes = 720;
  localparam int unsigned KeepAll     = 32'hffff_ffff;
  localparam logic [7:0]  PadFlag     = 8'h20;

  typedef enum int unsigned {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_mode_e;

  typedef enum int unsigned {
    FaultNone,
    FaultVersion,
    FaultShortLength,
    FaultPadZero,
    FaultPadOver,
    FaultOversize
  } fault_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        packet_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [15:0] member_offset_o;
  logic [15:0] member_length_o;
  logic [4:0]  format_count_o;
  logic [7:0]  packet_type_o;
  logic [31:0] header_ssrc_o;
  logic [15:0] body_length_o;
  logic        last_result_o;

  rtcp_compound_splitter_core #(
    .MAX_PACKET_BYTES(MaxBytes)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .data_byte_i,
    .packet_end_i,
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .member_offset_o,
    .member_length_o,
    .format_count_o,
    .packet_type_o,
    .header_ssrc_o,
    .body_length_o,
    .last_result_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Parser shadow state
  int unsigned pkt_pos;
  int unsigned mem_pos;
  int unsigned mem_start;
  int unsigned mem_size;
  logic [7:0]  hdr_first;
  logic [7:0]  hdr_type;
  logic [31:0] ssrc_acc;
  bit          err_seen;

  result_t     expected_results[$];
  result_t     result_head;
  logic [7:0]  pkt_buf[$];

  int unsigned errors;
  int unsigned n_bytes, n_packets, n_members, n_ends, n_malformed;
  int unsigned in_stall_cycles;
  int unsigned burst_left;
  bit          sender_smooth;
  bit          hold_req;

  function automatic void clear_parse_state();
    pkt_pos   = 0;
    mem_pos   = 0;
    mem_start = 0;
    mem_size  = 0;
    hdr_first = '0;
    hdr_type  = '0;
    ssrc_acc  = '0;
    err_seen  = 1'b0;
  endfunction

  function automatic result_t status_result(logic [1:0] st, logic last);
    result_t r;
    r = '0;
    r.status = st;
    r.last_result = last;
    return r;
  endfunction

  // Advance the shadow parser by one byte and queue what it should report
  function automatic void parse_byte(logic [7:0] b, logic fin);
    int unsigned m;
    int unsigned w;
    int unsigned logical;
    bit bad;
    bit emit;
    result_t r;
    bad = 1'b0;
    emit = 1'b0;
    logical = 0;
    if (err_seen) begin
      if (fin) clear_parse_state();
      return;
    end
    if (pkt_pos >= MaxBytes) begin
      bad = 1'b1;
    end else begin
      m = mem_pos;
      if (m == 0) begin
        hdr_first = b;
        mem_start = pkt_pos;
        if (b[7:6] != RtcpVersion) bad = 1'b1;
      end else if (m == 1) begin
        hdr_type = b;
      end else if (m == 2) begin
        mem_size = b;
      end else if (m == 3) begin
        w = ((mem_size & 32'hff) << 8) | b;
        mem_size = (w + 1) * 4;
        if (mem_size < HeaderBytes || mem_size > MaxBytes - mem_start) bad = 1'b1;
      end else if (m < 8) begin
        ssrc_acc = {ssrc_acc[23:0], b};
      end
      // member closes on its last byte; padding count sits there
      if (!bad && m >= 7 && m == mem_size - 1) begin
        logical = mem_size;
        if ((hdr_first & PadFlag) != 0) begin
          if (b == 0 || b > mem_size - 4) begin
            bad = 1'b1;
          end else begin
            logical -= b;
            if (logical < HeaderBytes) bad = 1'b1;
          end
        end
        if (!bad) emit = 1'b1;
      end
      if (!bad) begin
        mem_pos = emit ? 0 : m + 1;
        pkt_pos++;
      end
    end

    if (bad) begin
      expected_results.push_back(status_result(StatusMalformed, 1'b1));
      n_malformed++;
      if (fin) clear_parse_state();
      else err_seen = 1'b1;
      return;
    end

    if (emit) begin
      r = '0;
      r.status        = StatusMember;
      r.member_offset = 16'(mem_start);
      r.member_length = 16'(logical);
      r.format_count  = hdr_first[4:0];
      r.packet_type   = hdr_type;
      r.header_ssrc   = ssrc_acc;
      r.body_length   = 16'(logical - HeaderBytes);
      r.last_result   = !fin;
      expected_results.push_back(r);
      n_members++;
      if (fin) begin
        expected_results.push_back(status_result(StatusPacketEnd, 1'b1));
        n_ends++;
      end
    end else if (fin) begin
      expected_results.push_back(status_result(StatusMalformed, 1'b1));
      n_malformed++;
    end
    if (fin) clear_parse_state();
  endfunction

  // Append one member to pkt_buf, at most keep bytes of it
  function automatic void add_member(logic [1:0] ver, bit pad, logic [4:0] fc,
                                     logic [7:0] pt, logic [15:0] words,
                                     logic [31:0] ssrc, logic [7:0] pad_cnt,
                                     int unsigned keep);
    int unsigned total;
    int unsigned n;
    total = (int'(words) + 1) * 4;
    n = (keep < total) ? keep : total;
    for (int unsigned i = 0; i < n; i++) begin
      case (i)
        0: pkt_buf.push_back({ver, pad, fc});
        1: pkt_buf.push_back(pt);
        2: pkt_buf.push_back(words[15:8]);
        3: pkt_buf.push_back(words[7:0]);
        4, 5, 6, 7: pkt_buf.push_back(ssrc[8*(7-i) +: 8]);
        default: pkt_buf.push_back((pad && i == total - 1) ? pad_cnt : 8'($urandom));
      endcase
    end
  endfunction

  // One input beat: optional gap at a burst boundary, then hold until taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = 0;
      if (!sender_smooth) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      end
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    packet_end_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    parse_byte(b, fin);
    n_bytes++;
  endtask

  task automatic send_packet();
    n_packets++;
    foreach (pkt_buf[i]) send_byte(pkt_buf[i], i == pkt_buf.size() - 1);
    pkt_buf.delete();
  endtask

  // Well-formed members, field extremes, padding at its bounds
  task automatic test_valid_members();
    add_member(RtcpVersion, 1'b0, 5'd0, 8'd0, 16'd1, 32'h0000_0000, 8'd0, KeepAll);
    send_packet();
    add_member(RtcpVersion, 1'b1, 5'd31, 8'd255, 16'd2, 32'hffff_ffff, 8'd4, KeepAll);
    add_member(RtcpVersion, 1'b1, 5'd10, 8'd200, 16'd3, 32'h1234_5678, 8'd1, KeepAll);
    add_member(RtcpVersion, 1'b0, 5'd21, 8'd201, 16'd1, 32'h8765_4321, 8'd0, KeepAll);
    send_packet();
  endtask

  // Header, length and padding faults; each followed by a clean packet start
  task automatic test_malformed_members();
    // bad version on a single final byte
    pkt_buf.push_back(8'h00);
    send_packet();
    add_member(2'd0, 1'b0, 5'd1, 8'd200, 16'd1, $urandom, 8'd0, KeepAll);
    send_packet();
    add_member(2'd1, 1'b0, 5'd1, 8'd200, 16'd1, $urandom, 8'd0, KeepAll);
    send_packet();
    add_member(RtcpVersion, 1'b0, 5'd0, 8'd201, 16'd1, $urandom, 8'd0, KeepAll);
    add_member(2'd3, 1'b0, 5'd1, 8'd200, 16'd1, $urandom, 8'd0, KeepAll);
    send_packet();
    // length word too short
    add_member(RtcpVersion, 1'b0, 5'd0, 8'd200, 16'd0, $urandom, 8'd0, KeepAll);
    add_member(RtcpVersion, 1'b0, 5'd0, 8'd200, 16'd1, $urandom, 8'd0, KeepAll);
    send_packet();
    // packet ends inside a header or body
    add_member(RtcpVersion, 1'b0, 5'd2, 8'd202, 16'd1, $urandom, 8'd0, 3);
    send_packet();
    add_member(RtcpVersion, 1'b0, 5'd2, 8'd202, 16'd3, $urandom, 8'd0, 6);
    send_packet();
    add_member(RtcpVersion, 1'b0, 5'd2, 8'd202, 16'd1, $urandom, 8'd0, KeepAll);
    add_member(RtcpVersion, 1'b0, 5'd2, 8'd202, 16'd3, $urandom, 8'd0, 11);
    send_packet();
    // padding count zero, too large, and leaving under a header
    add_member(RtcpVersion, 1'b1, 5'd3, 8'd203, 16'd2, $urandom, 8'd0, KeepAll);
    add_member(RtcpVersion, 1'b0, 5'd3, 8'd203, 16'd1, $urandom, 8'd0, KeepAll);
    send_packet();
    add_member(RtcpVersion, 1'b1, 5'd3, 8'd203, 16'd2, $urandom, 8'd9, KeepAll);
    send_packet();
    add_member(RtcpVersion, 1'b1, 5'd3, 8'd203, 16'd2, $urandom, 8'd5, KeepAll);
    send_packet();
    add_member(RtcpVersion, 1'b1, 5'd3, 8'd203, 16'd1, $urandom, 8'd1, KeepAll);
    send_packet();
    // member would run past the offset range
    add_member(RtcpVersion, 1'b0, 5'd4, 8'd204, 16'd1, $urandom, 8'd0, KeepAll);
    add_member(RtcpVersion, 1'b0, 5'd4, 8'd204, 16'hffff, $urandom, 8'd0, 9);
    send_packet();
  endtask

  // Packets at the offset limit and three bytes beyond it
  task automatic test_full_size_packets();
    // one member filling the whole range
    add_member(RtcpVersion, 1'b0, 5'd7, 8'd200, 16'd63, 32'hdead_beef, 8'd0, KeepAll);
    send_packet();
    add_member(RtcpVersion, 1'b1, 5'd8, 8'd201, 16'd61, 32'h0f0f_f0f0, 8'd200, KeepAll);
    add_member(RtcpVersion, 1'b0, 5'd9, 8'd202, 16'd1, 32'hcafe_f00d, 8'd0, KeepAll);
    repeat (3) pkt_buf.push_back(8'($urandom));
    send_packet();
  endtask

  // Receiver holds off long enough for the result queue to fill
  task automatic test_result_backpressure();
    sender_smooth = 1'b1;
    hold_req = 1'b1;
    repeat (12) add_member(RtcpVersion, 1'b0, 5'($urandom), 8'($urandom), 16'd1,
                           $urandom, 8'd0, KeepAll);
    send_packet();
    sender_smooth = 1'b0;
  endtask

  // Mostly well-formed compound packets with random content, plus faults
  task automatic test_random_packets();
    int unsigned sent;
    int unsigned kind;
    int unsigned words;
    int unsigned size;
    int unsigned keep;
    int unsigned cut;
    logic [1:0]  ver;
    logic [7:0]  cnt;
    bit          pad;
    fault_e      fault;
    sent = 0;
    while (sent < RandomBytes) begin
      sender_smooth = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        repeat ($urandom_range(1, 24)) pkt_buf.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          words = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 5);
          size = (words + 1) * 4;
          ver = RtcpVersion;
          pad = (size >= 12) && ($urandom_range(0, 2) == 0);
          cnt = pad ? 8'($urandom_range(1, size - 8)) : 8'($urandom);
          keep = KeepAll;
          if ($urandom_range(0, 15) == 0) begin
            fault = fault_e'($urandom_range(FaultVersion, FaultOversize));
            case (fault)
              FaultVersion: begin
                ver = 2'($urandom_range(0, 2));
                if (ver == RtcpVersion) ver = 2'd3;
              end
              FaultShortLength: words = 0;
              FaultPadZero: begin
                pad = 1'b1;
                cnt = 8'd0;
              end
              FaultPadOver: begin
                pad = 1'b1;
                cnt = 8'($urandom_range(size - 7, 255));
              end
              FaultOversize: begin
                words = $urandom_range(16384, 65535);
                keep = $urandom_range(4, 12);
              end
              default: ;
            endcase
          end
          add_member(ver, pad, 5'($urandom), 8'($urandom), 16'(words), $urandom, cnt, keep);
        end
        // truncate or pad out some packets
        if (kind < 18 && pkt_buf.size() > 1) begin
          cut = $urandom_range(1, pkt_buf.size() - 1);
          while (pkt_buf.size() > cut) void'(pkt_buf.pop_back());
        end else if (kind < 24) begin
          repeat ($urandom_range(1, 6)) pkt_buf.push_back(8'($urandom));
        end
      end
      sent += pkt_buf.size();
      send_packet();
    end
    sender_smooth = 1'b0;
  endtask

  // Receiver stall pattern, with an on-demand long hold
  stall_mode_e stall_mode = StallNone;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned stall_phase = 0;

  always @(posedge clk_i) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HoldCycles;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(StallNone, StallPeriodic));
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      stall_phase++;
      case (stall_mode)
        StallNone:     out_stall_i <= 1'b0;
        StallLight:    out_stall_i <= ($urandom_range(0, 3) == 0);
        StallHeavy:    out_stall_i <= ($urandom_range(0, 3) != 0);
        StallPeriodic: out_stall_i <= (stall_phase % 7 < 3);
        default:       out_stall_i <= 1'b0;
      endcase
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing predicted: status %0d", status_o);
        errors++;
      end else begin
        result_head = expected_results.pop_front();
        check_field("status", 32'(result_head.status), 32'(status_o));
        check_field("member_offset", 32'(result_head.member_offset), 32'(member_offset_o));
        check_field("member_length", 32'(result_head.member_length), 32'(member_length_o));
        check_field("format_count", 32'(result_head.format_count), 32'(format_count_o));
        check_field("packet_type", 32'(result_head.packet_type), 32'(packet_type_o));
        check_field("header_ssrc", result_head.header_ssrc, header_ssrc_o);
        check_field("body_length", 32'(result_head.body_length), 32'(body_length_o));
        check_field("last_result", 32'(result_head.last_result), 32'(last_result_o));
      end
    end
  end

  // Watchdog on cycles without any beat on either side
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) in_stall_cycles++;
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("FAIL rtcp_compound_splitter_core");
        $finish;
      end
    end
  end

  initial begin
    clear_parse_state();
    errors = 0;
    n_bytes = 0;
    n_packets = 0;
    n_members = 0;
    n_ends = 0;
    n_malformed = 0;
    in_stall_cycles = 0;
    burst_left = 0;
    sender_smooth = 1'b0;
    hold_req = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_valid_members();
    test_malformed_members();
    test_result_backpressure();
    test_full_size_packets();
    test_random_packets();

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d packets, %0d bytes; checked %0d members, %0d packet ends, %0d malformed.",
             n_packets, n_bytes, n_members, n_ends, n_malformed);
    $display("Input side was held back for %0d cycles by result backpressure.",
             in_stall_cycles);
    if (errors == 0) begin
      $display("PASS rtcp_compound_splitter_core");
    end else begin
      $display("FAIL rtcp_compound_splitter_core");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/rcs_pkg.sv
hdl/rcs_parser.sv
hdl/rcs_result_queue.sv
hdl/rtcp_compound_splitter_core.sv
test/tb_top.sv
